[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, request and register codes, and the controller state type
// for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry
    localparam int DEF_COLS         = 80;
    localparam int DEF_ROWS         = 24;
    localparam int DEF_MAX_SESSIONS = 8;

    // Beat field widths
    localparam int REQ_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int POSX_W  = 7;
    localparam int POSY_W  = 5;
    localparam int SESS_W  = 3;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;
    localparam int SCNT_W  = 4;

    // Request codes
    typedef logic [REQ_W-1:0] t_req_code;
    localparam t_req_code REQ_PUT_CHAR = 3'd0;
    localparam t_req_code REQ_PUT_AT   = 3'd1;
    localparam t_req_code REQ_SWITCH   = 3'd2;
    localparam t_req_code REQ_CLEAR    = 3'd3;
    localparam t_req_code REQ_READ     = 3'd4;

    // Control characters for put-char
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TEXT_COLOR    = 1'b0;
    localparam t_cfg_idx CFG_SESSION_COUNT = 1'b1;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST    = 8'd15;
    localparam logic [SCNT_W-1:0]  SESSION_COUNT_RST = 4'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [POSX_W-1:0] cursor_col;
        logic [POSY_W-1:0] cursor_row;
        logic [SESS_W-1:0] active_session;
        logic [CELL_W-1:0] cell_value;
        logic              did_scroll;
        logic              rejected;
    } t_rsp;

endpackage

[rtl/tcw_req_if.sv]
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [POSX_W-1:0] pos_x;
    logic [POSY_W-1:0] pos_y;
    logic [SESS_W-1:0] session_index;

    modport source (
        output valid, req_type, char_code, pos_x, pos_y, session_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, pos_x, pos_y, session_index,
        output ready
    );
endinterface

[rtl/tcw_rsp_if.sv]
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POSX_W-1:0] cursor_col;
    logic [POSY_W-1:0] cursor_row;
    logic [SESS_W-1:0] active_session;
    logic [CELL_W-1:0] cell_value;
    logic              did_scroll;
    logic              rejected;

    modport source (
        output valid, cursor_col, cursor_row, active_session, cell_value,
               did_scroll, rejected,
        input  ready
    );
    modport sink (
        input  valid, cursor_col, cursor_row, active_session, cell_value,
               did_scroll, rejected,
        output ready
    );
endinterface

[rtl/tcw_cell_ram.sv]
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Simple dual-port cell memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH = 15360,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top
// Multi-session text console: cell stores, cursors and request controller.
// ----------------------------------------------------------------------------
// A request beat is taken, then executed in the execute state, and its result
// beat is loaded into the output register in the result state, where the next
// request beat may already be taken; the result state waits while the output
// register still holds a result that has not been taken. The cell memory's
// registered read port serves read-cell requests between those two steps.
// All sessions share one cell memory of MAX_SESSIONS*ROWS*COLS
// 16-bit words. Each session row has a valid bit in flip-flops; reset, clear
// and scroll only drop valid bits, so there is no clearing pass after reset
// and a cleared row reads as zero. Scrolling rotates a per-session row offset
// instead of moving cells. The first write into a row that is not valid first
// sweeps zeros across that row in the fill state before it executes. A
// finished result waits in the output register while the next request beat
// is accepted; the request after that waits until the result beat is taken.
// Configuration writes are taken at any time and are meant for idle periods.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLS         = DEF_COLS,
    parameter int ROWS         = DEF_ROWS,
    parameter int MAX_SESSIONS = DEF_MAX_SESSIONS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcw_req_if.sink               i_req,
    tcw_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
    localparam int NROWS = MAX_SESSIONS * ROWS;
    localparam int RFW   = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int DEPTH = NROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    // Latched request beat
    t_req_code         r_req_type;
    logic [CHAR_W-1:0] r_char;
    logic [POSX_W-1:0] r_pos_x;
    logic [POSY_W-1:0] r_pos_y;
    logic [SESS_W-1:0] r_sess_idx;

    // Registers
    logic [COLOR_W-1:0] r_text_color;
    logic [SCNT_W-1:0]  r_sess_count;

    // Per-session cursor and scroll offset, per-row valid bits
    logic [SW-1:0]    r_shown;
    logic [CW-1:0]    r_cur_x [MAX_SESSIONS];
    logic [RW-1:0]    r_cur_y [MAX_SESSIONS];
    logic [RW-1:0]    r_off   [MAX_SESSIONS];
    logic [NROWS-1:0] r_row_valid;

    // Row fill sweep
    logic [RFW-1:0] r_fill_row;
    logic [CW-1:0]  r_fill_col;

    // Result flags captured at execute
    logic r_scroll;
    logic r_rej;
    logic r_rd_ok;

    // Output register
    logic r_out_valid;
    t_rsp r_res;

    // ------------------------------------------------------------------
    // Execute decode
    // ------------------------------------------------------------------
    logic [CW-1:0]   cx;
    logic [RW-1:0]   cy;
    logic [RW-1:0]   off;
    logic            pos_ok;
    logic            is_cr;
    logic            is_lf;
    logic            wr_need;
    logic            rd_need;
    logic [CW-1:0]   t_x;
    logic [RW-1:0]   t_y;
    logic [CW:0]     px_n;
    logic [RW:0]     py_n;
    logic            wrap;
    logic [CW-1:0]   x2;
    logic [RW:0]     y2;
    logic            scroll;
    logic [RW-1:0]   y3;
    logic [RW:0]     prow_sum;
    logic [RW-1:0]   prow;
    logic [RFW-1:0]  trow;
    logic [RFW-1:0]  top_row;
    logic [AW-1:0]   taddr;
    logic [AW-1:0]   fill_addr;
    logic            row_ok;
    logic            rej;
    logic            fill_go;
    logic            exec_fire;
    logic            fill_last;
    logic            out_free;
    logic            in_ready;
    logic            in_fire;
    logic            resp_fire;

    // Memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CELL_W-1:0] mem_rdata;

    always_comb begin
        cx     = r_cur_x[r_shown];
        cy     = r_cur_y[r_shown];
        off    = r_off[r_shown];
        pos_ok = (int'(r_pos_x) < COLS) && (int'(r_pos_y) < ROWS);
        is_cr  = (r_char == CHAR_CR);
        is_lf  = (r_char == CHAR_LF);
        rej    = (int'(r_sess_idx) >= int'(r_sess_count)) ||
                 (int'(r_sess_idx) >= MAX_SESSIONS);

        wr_need = 1'b0;
        rd_need = 1'b0;
        t_x     = CW'(r_pos_x);
        t_y     = RW'(r_pos_y);
        px_n    = (CW+1)'(cx);
        py_n    = (RW+1)'(cy);

        case (r_req_type)
            REQ_PUT_CHAR: begin
                t_x = cx;
                t_y = cy;
                if (is_cr) begin
                    px_n = '0;
                end else if (is_lf) begin
                    py_n = (RW+1)'(cy) + (RW+1)'(1);
                end else begin
                    wr_need = 1'b1;
                    px_n    = (CW+1)'(cx) + (CW+1)'(1);
                end
            end
            REQ_PUT_AT: begin
                wr_need = pos_ok;
            end
            REQ_READ: begin
                rd_need = pos_ok;
            end
            default: begin
            end
        endcase

        // Wrap to the next row, then scroll on row overflow
        wrap   = (px_n >= (CW+1)'(COLS));
        x2     = wrap ? '0 : px_n[CW-1:0];
        y2     = wrap ? py_n + (RW+1)'(1) : py_n;
        scroll = (y2 >= (RW+1)'(ROWS));
        y3     = scroll ? RW'(ROWS - 1) : y2[RW-1:0];

        // Logical row to physical row through the session's offset
        prow_sum = (RW+1)'(t_y) + (RW+1)'(off);
        prow     = (prow_sum >= (RW+1)'(ROWS)) ? RW'(prow_sum - (RW+1)'(ROWS))
                                               : prow_sum[RW-1:0];
        trow     = RFW'(int'(r_shown) * ROWS + int'(prow));
        top_row  = RFW'(int'(r_shown) * ROWS + int'(off));
        taddr    = AW'(int'(trow) * COLS + int'(t_x));
        fill_addr = AW'(int'(r_fill_row) * COLS + int'(r_fill_col));
        row_ok   = r_row_valid[trow];

        fill_go   = (r_state == S_EXEC) && wr_need && !row_ok;
        exec_fire = (r_state == S_EXEC) && !fill_go;
        fill_last = (r_fill_col == CW'(COLS - 1));

        out_free  = !r_out_valid || o_rsp.ready;
        in_ready  = (r_state == S_IDLE) || ((r_state == S_RESP) && out_free);
        in_fire   = i_req.valid && in_ready;
        resp_fire = (r_state == S_RESP) && out_free;

        mem_we    = (exec_fire && wr_need) || (r_state == S_FILL);
        mem_waddr = (r_state == S_FILL) ? fill_addr : taddr;
        mem_wdata = (r_state == S_FILL) ? '0 : {r_text_color, r_char};
        mem_re    = exec_fire && rd_need;
    end

    // ------------------------------------------------------------------
    // Controller next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = fill_go ? S_FILL : S_RESP;
            end
            S_FILL: begin
                if (fill_last) n_state = S_EXEC;
            end
            S_RESP: begin
                if (out_free) n_state = in_fire ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_text_color <= TEXT_COLOR_RST;
            r_sess_count <= SESSION_COUNT_RST;
            r_shown      <= '0;
            r_row_valid  <= '0;
            for (int i = 0; i < MAX_SESSIONS; i++) begin
                r_cur_x[i] <= '0;
                r_cur_y[i] <= '0;
                r_off[i]   <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEXT_COLOR:    r_text_color <= COLOR_W'(i_cfg_data);
                    CFG_SESSION_COUNT: r_sess_count <= SCNT_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            // Mark the swept row valid
            if ((r_state == S_FILL) && fill_last) begin
                r_row_valid[r_fill_row] <= 1'b1;
            end

            if (exec_fire) begin
                case (r_req_type)
                    REQ_PUT_CHAR: begin
                        r_cur_x[r_shown] <= x2;
                        r_cur_y[r_shown] <= y3;
                        // Rotate the window: the old top row becomes the
                        // new, blank bottom row
                        if (scroll) begin
                            r_off[r_shown] <= (off == RW'(ROWS - 1)) ? '0
                                                                     : off + RW'(1);
                            r_row_valid[top_row] <= 1'b0;
                        end
                    end
                    REQ_SWITCH: begin
                        if (!rej) r_shown <= SW'(r_sess_idx);
                    end
                    REQ_CLEAR: begin
                        for (int i = 0; i < ROWS; i++) begin
                            r_row_valid[RFW'(int'(r_shown) * ROWS + i)] <= 1'b0;
                        end
                        r_cur_x[r_shown] <= '0;
                        r_cur_y[r_shown] <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            if (resp_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type <= i_req.req_type;
            r_char     <= i_req.char_code;
            r_pos_x    <= i_req.pos_x;
            r_pos_y    <= i_req.pos_y;
            r_sess_idx <= i_req.session_index;
        end

        if (fill_go) begin
            r_fill_row <= trow;
            r_fill_col <= '0;
        end else if (r_state == S_FILL) begin
            r_fill_col <= r_fill_col + CW'(1);
        end

        if (exec_fire) begin
            r_scroll <= (r_req_type == REQ_PUT_CHAR) && scroll;
            r_rej    <= (r_req_type == REQ_SWITCH) && rej;
            r_rd_ok  <= rd_need && row_ok;
        end

        // Cursor arrays already hold the post-request state here
        if (resp_fire) begin
            r_res.cursor_col     <= POSX_W'(r_cur_x[r_shown]);
            r_res.cursor_row     <= POSY_W'(r_cur_y[r_shown]);
            r_res.active_session <= SESS_W'(r_shown);
            r_res.cell_value     <= r_rd_ok ? mem_rdata : '0;
            r_res.did_scroll     <= r_scroll;
            r_res.rejected       <= r_rej;
        end
    end

    // ------------------------------------------------------------------
    // Cell memory
    // ------------------------------------------------------------------
    tcw_cell_ram #(
        .DEPTH (DEPTH),
        .WIDTH (CELL_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (taddr),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Channel outputs
    // ------------------------------------------------------------------
    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.cursor_col     = r_res.cursor_col;
    assign o_rsp.cursor_row     = r_res.cursor_row;
    assign o_rsp.active_session = r_res.active_session;
    assign o_rsp.cell_value     = r_res.cell_value;
    assign o_rsp.did_scroll     = r_res.did_scroll;
    assign o_rsp.rejected       = r_res.rejected;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-session text console writer.
// ----------------------------------------------------------------------------
// Drives request beats through the valid/ready request channel and keeps a
// bit-exact shadow of every session's screen, cursor and the shown session.
// Each accepted request beat queues the status the console must report. Each
// result beat is checked field by field against the oldest queued status.
// Directed requests cover the field extremes and every request kind. Random
// traffic follows, as text runs, line-feed runs, positioned writes, reads,
// switches and clears, under several color and session-count settings.
// ----------------------------------------------------------------------------
module tb_top import tcw_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS      = DEF_COLS;
    localparam int ROWS      = DEF_ROWS;
    localparam int MAX_SESS  = DEF_MAX_SESSIONS;
    // Worst request: a first write into a dropped row sweeps a whole row.
    localparam int SETTLE_CYCLES = COLS + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 100;

    // First code past the defined request kinds; the console must ignore it.
    localparam t_req_code REQ_UNUSED_FIRST = REQ_READ + 1'b1;

    typedef struct packed {
        t_req_code         kind;
        logic [CHAR_W-1:0] ch;
        logic [POSX_W-1:0] x;
        logic [POSY_W-1:0] y;
        logic [SESS_W-1:0] sess;
    } t_req_beat;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the console: every session's cells and cursor, plus registers
    logic [CELL_W-1:0]  screen  [MAX_SESS][ROWS][COLS];
    logic [POSX_W-1:0]  cur_col [MAX_SESS];
    logic [POSY_W-1:0]  cur_row [MAX_SESS];
    logic [SESS_W-1:0]  shown;
    logic [COLOR_W-1:0] color;
    logic [SCNT_W-1:0]  sess_limit;

    t_rsp        expected_status[$];
    int unsigned requests_sent  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          rsp_stall      = 0;
    bit          idle_on        = 1'b1;
    bit          idling_allowed = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Apply one request to the shadow console and return the status it reports.
    function automatic t_rsp console_apply(t_req_beat b);
        t_rsp              view;
        int                col, row, r, c;
        logic              scrolled, refused;
        logic [CELL_W-1:0] cell_word;
        scrolled  = 1'b0;
        refused   = 1'b0;
        cell_word = '0;
        col       = cur_col[shown];
        row       = cur_row[shown];
        case (b.kind)
            REQ_PUT_CHAR: begin
                // Return and line feed only move the cursor.
                if (b.ch == CHAR_CR) begin
                    col = 0;
                end else if (b.ch == CHAR_LF) begin
                    row = row + 1;
                end else begin
                    screen[shown][row][col] = {color, b.ch};
                    col = col + 1;
                end
                if (col >= COLS) begin
                    col = 0;
                    row = row + 1;
                end
                // Past the last row: shift the shown session up, blank its
                // last row and pin the cursor there.
                if (row >= ROWS) begin
                    for (r = 0; r < ROWS - 1; r++)
                        for (c = 0; c < COLS; c++)
                            screen[shown][r][c] = screen[shown][r + 1][c];
                    for (c = 0; c < COLS; c++)
                        screen[shown][ROWS - 1][c] = '0;
                    row      = ROWS - 1;
                    scrolled = 1'b1;
                end
                cur_col[shown] = POSX_W'(col);
                cur_row[shown] = POSY_W'(row);
            end
            REQ_PUT_AT: begin
                if (b.x < COLS && b.y < ROWS)
                    screen[shown][b.y][b.x] = {color, b.ch};
            end
            REQ_SWITCH: begin
                if (b.sess >= sess_limit || int'(b.sess) >= MAX_SESS)
                    refused = 1'b1;
                else
                    shown = b.sess;
            end
            REQ_CLEAR: begin
                for (r = 0; r < ROWS; r++)
                    for (c = 0; c < COLS; c++)
                        screen[shown][r][c] = '0;
                cur_col[shown] = '0;
                cur_row[shown] = '0;
            end
            REQ_READ: begin
                if (b.x < COLS && b.y < ROWS)
                    cell_word = screen[shown][b.y][b.x];
            end
            default: begin
            end
        endcase
        view.cursor_col     = cur_col[shown];
        view.cursor_row     = cur_row[shown];
        view.active_session = shown;
        view.cell_value     = cell_word;
        view.did_scroll     = scrolled;
        view.rejected       = refused;
        return view;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Result side: check each accepted beat, then hold ready low for a drawn
    // number of cycles so stalls land on every phase of the console's work.
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $error("result beat with no request outstanding");
            end else begin
                want = expected_status.pop_front();
                check_field("cursor_col", want.cursor_col, rsp_ch.cursor_col);
                check_field("cursor_row", want.cursor_row, rsp_ch.cursor_row);
                check_field("active_session", want.active_session,
                            rsp_ch.active_session);
                check_field("cell_value", want.cell_value, rsp_ch.cell_value);
                check_field("did_scroll", want.did_scroll, rsp_ch.did_scroll);
                check_field("rejected", want.rejected, rsp_ch.rejected);
            end
            rsp_stall = idle_on ? $urandom_range(0, 8) : 0;
        end
        if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Send one request beat. Valid stays high after acceptance so a following
    // beat with no gap goes out back to back; anything that waits must go
    // through drain_results, which drops valid first.
    task automatic issue_request(input t_req_beat b);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= b.kind;
        req_ch.char_code     <= b.ch;
        req_ch.pos_x         <= b.x;
        req_ch.pos_y         <= b.y;
        req_ch.session_index <= b.sess;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_status.push_back(console_apply(b));
        requests_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let a row sweep finish.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TEXT_COLOR:    color      = data[COLOR_W-1:0];
            CFG_SESSION_COUNT: sess_limit = data[SCNT_W-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_req_beat beat_of(t_req_code kind, logic [CHAR_W-1:0] ch,
                                          logic [POSX_W-1:0] x, logic [POSY_W-1:0] y,
                                          logic [SESS_W-1:0] sess);
        t_req_beat b;
        b.kind = kind;
        b.ch   = ch;
        b.x    = x;
        b.y    = y;
        b.sess = sess;
        return b;
    endfunction

    // Every field random over its full width; callers narrow what matters.
    function automatic t_req_beat random_beat(t_req_code kind);
        return beat_of(kind, CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1)),
                       POSX_W'($urandom_range(0, (1 << POSX_W) - 1)),
                       POSY_W'($urandom_range(0, (1 << POSY_W) - 1)),
                       SESS_W'($urandom_range(0, (1 << SESS_W) - 1)));
    endfunction

    // Mostly aim inside the screen; now and then keep the wild position.
    function automatic void aim_on_screen(inout t_req_beat b);
        if ($urandom_range(0, 6) != 0) begin
            b.x = POSX_W'($urandom_range(0, COLS - 1));
            b.y = POSY_W'($urandom_range(0, ROWS - 1));
        end
    endfunction

    // Random traffic in bursts of related requests, so cursors walk far enough
    // to wrap lines and scroll, and reads land on text that was written.
    task automatic run_traffic(input int unsigned count);
        int unsigned target;
        int          pick, len;
        t_req_beat   b;
        target = requests_sent + count;
        while (requests_sent < target) begin
            pick    = $urandom_range(0, 99);
            idle_on = idling_allowed && ($urandom_range(0, 3) != 0);
            if (pick < 50) begin
                // Text run, sometimes longer than a line, often ended by CR LF
                len = $urandom_range(1, COLS + 20);
                repeat (len) issue_request(random_beat(REQ_PUT_CHAR));
                if ($urandom_range(0, 1)) begin
                    b = random_beat(REQ_PUT_CHAR);
                    b.ch = CHAR_CR;
                    issue_request(b);
                    b.ch = CHAR_LF;
                    issue_request(b);
                end
            end else if (pick < 65) begin
                // Line-feed run to push cursors down to the bottom and beyond
                len = $urandom_range(5, 30);
                repeat (len) begin
                    b = random_beat(REQ_PUT_CHAR);
                    b.ch = ($urandom_range(0, 5) == 0) ? CHAR_CR : CHAR_LF;
                    issue_request(b);
                end
            end else if (pick < 75) begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    b = random_beat(REQ_PUT_AT);
                    aim_on_screen(b);
                    issue_request(b);
                end
            end else if (pick < 85) begin
                // Reads, half of them along the row the cursor is on
                len = $urandom_range(1, 6);
                repeat (len) begin
                    b = random_beat(REQ_READ);
                    aim_on_screen(b);
                    if ($urandom_range(0, 1))
                        b.y = cur_row[shown];
                    issue_request(b);
                end
            end else if (pick < 93) begin
                issue_request(random_beat(REQ_SWITCH));
            end else if (pick < 96) begin
                issue_request(random_beat(REQ_CLEAR));
            end else begin
                issue_request(random_beat(t_req_code'($urandom_range(
                    int'(REQ_UNUSED_FIRST), (1 << REQ_W) - 1))));
            end
        end
    endtask

    // Fresh console: reads all zero, ignored kinds report the home cursor.
    task automatic test_reset_contents();
        t_req_code k;
        issue_request(beat_of(REQ_READ, 8'h00, '0, '0, '0));
        issue_request(beat_of(REQ_READ, 8'h00, POSX_W'(COLS - 1), POSY_W'(ROWS - 1), '0));
        issue_request(beat_of(REQ_READ, 8'hFF, '1, '1, '1));
        for (k = REQ_UNUSED_FIRST; k != REQ_PUT_CHAR; k = k + 1'b1)
            issue_request(beat_of(k, 8'hFF, '1, '1, '1));
    endtask

    // Each request kind at least once, with return, line feed, out-of-range positions
    // and refused switches.
    task automatic test_each_request();
        issue_request(beat_of(REQ_PUT_AT, 8'h00, '0, '0, '0));
        issue_request(beat_of(REQ_PUT_AT, 8'hFF, POSX_W'(COLS - 1), POSY_W'(ROWS - 1), '0));
        issue_request(beat_of(REQ_PUT_AT, 8'hAA, '1, '1, '0));
        issue_request(beat_of(REQ_READ, 8'h00, POSX_W'(COLS - 1), POSY_W'(ROWS - 1), '0));
        issue_request(beat_of(REQ_READ, 8'h00, '0, '0, '0));
        issue_request(beat_of(REQ_PUT_CHAR, 8'h41, '0, '0, '0));
        issue_request(beat_of(REQ_PUT_CHAR, CHAR_CR, '0, '0, '0));
        issue_request(beat_of(REQ_PUT_CHAR, CHAR_LF, '0, '0, '0));
        issue_request(beat_of(REQ_PUT_CHAR, 8'hFF, '0, '0, '0));
        issue_request(beat_of(REQ_READ, 8'h00, '0, 5'd1, '0));
        issue_request(beat_of(REQ_SWITCH, 8'h00, '0, '0, SESS_W'(MAX_SESS - 1)));
        issue_request(beat_of(REQ_SWITCH, 8'h00, '0, '0, 3'd4));
        issue_request(beat_of(REQ_SWITCH, 8'h00, '0, '0, 3'd5));
        issue_request(beat_of(REQ_SWITCH, 8'h00, '0, '0, '0));
        issue_request(beat_of(REQ_CLEAR, 8'h00, '0, '0, '0));
        issue_request(beat_of(REQ_READ, 8'h00, POSX_W'(COLS - 1), POSY_W'(ROWS - 1), '0));
    endtask

    // Both registers at their extremes and one value in between.
    task automatic test_register_extremes();
        set_register(CFG_TEXT_COLOR, 8'h00);
        set_register(CFG_SESSION_COUNT, 8'd1);
        run_traffic(150);
        set_register(CFG_TEXT_COLOR, 8'hFF);
        set_register(CFG_SESSION_COUNT, 8'd8);
        run_traffic(150);
        set_register(CFG_TEXT_COLOR, 8'hA5);
        set_register(CFG_SESSION_COUNT, 8'd2);
        run_traffic(150);
    endtask

    task automatic test_random_traffic();
        repeat (4) begin
            set_register(CFG_TEXT_COLOR,
                         CFG_DATA_W'($urandom_range(0, (1 << COLOR_W) - 1)));
            set_register(CFG_SESSION_COUNT, CFG_DATA_W'($urandom_range(1, MAX_SESS)));
            run_traffic(300);
        end
    endtask

    // No idling on either side: requests and results at full rate.
    task automatic test_back_to_back();
        idling_allowed = 1'b0;
        set_register(CFG_SESSION_COUNT, 8'd8);
        run_traffic(250);
        idling_allowed = 1'b1;
        idle_on        = 1'b1;
    endtask

    initial begin
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_PUT_CHAR;
        req_ch.char_code     <= '0;
        req_ch.pos_x         <= '0;
        req_ch.pos_y         <= '0;
        req_ch.session_index <= '0;

        // Shadow starts from the reset state of the console
        foreach (screen[s, r, c]) screen[s][r][c] = '0;
        foreach (cur_col[s]) begin
            cur_col[s] = '0;
            cur_row[s] = '0;
        end
        shown      = '0;
        color      = TEXT_COLOR_RST;
        sess_limit = SESSION_COUNT_RST;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_each_request();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();

        drain_results();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
